[design/rsfa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Region statistics package
// Shared constants, types and helper functions of the region surface
// feature accumulator.
// ----------------------------------------------------------------------------
package rsfa_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int HIST_SIDE   = 11;
  localparam int COORD_BITS  = 12;

  localparam int HALF_SIDE  = (HIST_SIDE - 1) / 2;
  localparam int NBINS      = HIST_SIDE * HIST_SIDE;
  localparam int HIST_DEPTH = MAX_REGIONS * NBINS;
  localparam int REGION_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int BIN_W      = $clog2(NBINS);
  localparam int BIG_W      = $clog2(NBINS + 1);
  localparam int AXIS_W     = $clog2(HIST_SIDE);
  localparam int HADDR_W    = $clog2(HIST_DEPTH);

  localparam int LABEL_W  = 7;
  localparam int PIX_W    = 12;
  localparam int VEC_W    = 16;
  localparam int CNT_W    = 20;
  localparam int SUM_W    = 36;
  localparam int B2_W     = COORD_BITS + 1;
  localparam int WIDX_W   = 5;
  localparam int WORD_W   = 49;
  localparam int MODE_W   = 6;
  localparam int QUO_W    = 18;
  localparam int DIV_QB   = 17;
  localparam int RATIO_W  = CNT_W + 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam int BIN_RATIO      = 200;
  localparam int PLANAR_LIMIT   = 8;
  localparam int CURVED1D_LIMIT = 20;
  localparam int BOX2_HI        = (2 ** COORD_BITS) - 1;
  localparam int BOX2_LO        = -(2 ** COORD_BITS);

  localparam int MODE_HIST = 0;
  localparam int MODE_CURV = 1;
  localparam int MODE_MNRM = 2;
  localparam int MODE_MPOS = 3;
  localparam int MODE_BOX3 = 4;
  localparam int MODE_BOX2 = 5;
  localparam logic [MODE_W-1:0] MODE_RESET = 6'd63;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [WIDX_W-1:0] W_COUNT   = 5'd0;
  localparam logic [WIDX_W-1:0] W_MEAN_N0 = 5'd1;
  localparam logic [WIDX_W-1:0] W_MEAN_P0 = 5'd4;
  localparam logic [WIDX_W-1:0] W_MEAN_P2 = 5'd6;
  localparam logic [WIDX_W-1:0] W_B3MIN0  = 5'd7;
  localparam logic [WIDX_W-1:0] W_B3MAX0  = 5'd10;
  localparam logic [WIDX_W-1:0] W_B2MIN_X = 5'd13;
  localparam logic [WIDX_W-1:0] W_B2MIN_Y = 5'd14;
  localparam logic [WIDX_W-1:0] W_B2MAX_X = 5'd15;
  localparam logic [WIDX_W-1:0] W_B2MAX_Y = 5'd16;
  localparam logic [WIDX_W-1:0] W_CLASS   = 5'd17;
  localparam logic [WIDX_W-1:0] W_VOLUME  = 5'd18;

  localparam logic [1:0] CLS_UNDEF    = 2'd0;
  localparam logic [1:0] CLS_PLANAR   = 2'd1;
  localparam logic [1:0] CLS_CURVED1D = 2'd2;
  localparam logic [1:0] CLS_CURVED2D = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    logic [2:0][SUM_W-1:0]       nsum;
    logic [2:0][SUM_W-1:0]       psum;
    logic [2:0][VEC_W-1:0]       b3min;
    logic [2:0][VEC_W-1:0]       b3max;
    logic [1:0][B2_W-1:0]        b2min;
    logic [1:0][B2_W-1:0]        b2max;
  } rstate_t;

  typedef struct packed {
    logic                        action;
    logic [REGION_W-1:0]         region;
    logic [BIN_W-1:0]            bin;
    logic [1:0][COORD_BITS-1:0]  pix;
    logic [2:0][VEC_W-1:0]       nrm;
    logic [2:0][VEC_W-1:0]       pos;
  } qent_t;

  typedef enum logic [3:0] {
    BS_INIT, BS_IDLE, BS_ACC, BS_RO_LAT, BS_WALK, BS_WALK_END,
    BS_WORD, BS_DIV, BS_MUL, BS_EMIT, BS_CLR
  } bstate_t;

  function automatic rstate_t rstate_reset();
    rstate_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      r.b3min[i] = 16'h7FFF;
      r.b3max[i] = 16'h8000;
    end
    for (int i = 0; i < 2; i++) begin
      r.b2min[i] = B2_W'(BOX2_HI);
      r.b2max[i] = B2_W'(BOX2_LO);
    end
    return r;
  endfunction

  function automatic logic [AXIS_W-1:0] hist_axis(input logic signed [VEC_W-1:0] v);
    logic signed [23:0] t;
    logic [23:0] u;
    t = 24'(v) * 24'(HALF_SIDE) + 24'(HALF_SIDE * 16384);
    u = (24'(t) + 24'd8192) >> 14;
    if (t < 0) begin
      return '0;
    end else if (u > 24'(HIST_SIDE - 1)) begin
      return AXIS_W'(HIST_SIDE - 1);
    end
    return AXIS_W'(u);
  endfunction

endpackage
`default_nettype wire

[design/rsfa_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Region statistics front end
// Accepts requests, drops those without a region and computes the region
// number and histogram bin before queueing.
// ----------------------------------------------------------------------------
module rsfa_front (
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_action,
  input  wire logic [rsfa_pkg::LABEL_W-1:0] in_label,
  input  wire logic [rsfa_pkg::PIX_W-1:0]  in_pix_x,
  input  wire logic [rsfa_pkg::PIX_W-1:0]  in_pix_y,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_normal_x,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_normal_y,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_normal_z,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_pos_x,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_pos_y,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_pos_z,
  input  wire logic                        q_full,
  input  wire logic                        init_busy,
  output logic                             push,
  output rsfa_pkg::qent_t                  push_data
);

  logic                          lbl_ok;
  logic [rsfa_pkg::AXIS_W-1:0]   ix;
  logic [rsfa_pkg::AXIS_W-1:0]   iy;

  always_comb begin
    lbl_ok = (in_label != '0) && (in_label <= rsfa_pkg::LABEL_W'(rsfa_pkg::MAX_REGIONS));
    in_ready = !q_full && !init_busy;
    push = in_valid && in_ready && lbl_ok;
    ix = rsfa_pkg::hist_axis(in_normal_x);
    iy = rsfa_pkg::hist_axis(in_normal_y);
    push_data.action = in_action;
    push_data.region = rsfa_pkg::REGION_W'(in_label - rsfa_pkg::LABEL_W'(1));
    push_data.bin = rsfa_pkg::BIN_W'(ix * rsfa_pkg::HIST_SIDE + iy);
    push_data.pix[0] = in_pix_x[rsfa_pkg::COORD_BITS-1:0];
    push_data.pix[1] = in_pix_y[rsfa_pkg::COORD_BITS-1:0];
    push_data.nrm[0] = in_normal_x;
    push_data.nrm[1] = in_normal_y;
    push_data.nrm[2] = in_normal_z;
    push_data.pos[0] = in_pos_x;
    push_data.pos[1] = in_pos_y;
    push_data.pos[2] = in_pos_z;
  end

endmodule
`default_nettype wire

[design/rsfa_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Region statistics request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rsfa_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rsfa_pkg::qent_t push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 valid,
  output rsfa_pkg::qent_t      head
);

  rsfa_pkg::qent_t ent_r [2];
  logic            wp_r;
  logic            wp_nxt;
  logic            rp_r;
  logic            rp_nxt;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;

  always_comb begin
    full = (cnt_r == 2'd2);
    valid = (cnt_r != 2'd0);
    head = ent_r[rp_r];
    wp_nxt = push ? !wp_r : wp_r;
    rp_nxt = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[design/rsfa_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Region statistics mean divider
// Restoring divider, one quotient bit per cycle, rounding to nearest with
// ties away from zero. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module rsfa_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [rsfa_pkg::SUM_W-1:0] dividend,
  input  wire logic [rsfa_pkg::CNT_W-1:0]       divisor,
  output logic                                  done,
  output logic signed [rsfa_pkg::QUO_W-1:0]     quotient
);

  logic                              run_r;
  logic                              run_nxt;
  logic                              done_r;
  logic                              done_nxt;
  logic [4:0]                        cnt_r;
  logic [4:0]                        cnt_nxt;
  logic                              neg_r;
  logic                              zero_r;
  logic [rsfa_pkg::CNT_W-1:0]        n_r;
  logic [rsfa_pkg::DIV_QB-1:0]       a_r;
  logic [rsfa_pkg::CNT_W-1:0]        rem_r;
  logic [rsfa_pkg::DIV_QB-1:0]       q_r;
  logic [rsfa_pkg::SUM_W-1:0]        mag;
  logic [rsfa_pkg::SUM_W:0]          a_init;
  logic [rsfa_pkg::CNT_W:0]          remx;
  logic                              ge;

  always_comb begin
    mag = dividend[rsfa_pkg::SUM_W-1] ? rsfa_pkg::SUM_W'(-dividend)
                                      : rsfa_pkg::SUM_W'(dividend);
    a_init = (rsfa_pkg::SUM_W+1)'(mag) + (rsfa_pkg::SUM_W+1)'(divisor >> 1);
    remx = {rem_r, a_r[rsfa_pkg::DIV_QB-1]};
    ge = (remx >= {1'b0, n_r});
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(rsfa_pkg::DIV_QB - 1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    done = done_r;
    if (zero_r) begin
      quotient = '0;
    end else if (neg_r) begin
      quotient = -rsfa_pkg::QUO_W'(q_r);
    end else begin
      quotient = rsfa_pkg::QUO_W'(q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[rsfa_pkg::SUM_W-1];
      zero_r <= (divisor == '0);
      n_r <= divisor;
      a_r <= a_init[rsfa_pkg::DIV_QB-1:0];
      rem_r <= a_init[rsfa_pkg::SUM_W:rsfa_pkg::DIV_QB];
      q_r <= '0;
    end else if (run_r) begin
      a_r <= {a_r[rsfa_pkg::DIV_QB-2:0], 1'b0};
      rem_r <= ge ? rsfa_pkg::CNT_W'(remx - {1'b0, n_r}) : remx[rsfa_pkg::CNT_W-1:0];
      q_r <= {q_r[rsfa_pkg::DIV_QB-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[design/rsfa_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Region statistics back end
// Holds the per-region state and histogram memories, applies pixel
// updates and sequences the readout of the feature words.
// ----------------------------------------------------------------------------
module rsfa_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [rsfa_pkg::MODE_W-1:0]  mode,
  input  wire logic                         q_valid,
  input  wire rsfa_pkg::qent_t              q_head,
  output logic                              pop,
  output logic                              init_busy,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rsfa_pkg::LABEL_W-1:0]      out_region,
  output logic [rsfa_pkg::WIDX_W-1:0]       out_word_index,
  output logic signed [rsfa_pkg::WORD_W-1:0] out_word_value,
  output logic                              out_last_word
);

  rsfa_pkg::rstate_t                  rmem [rsfa_pkg::MAX_REGIONS];
  logic [rsfa_pkg::CNT_W-1:0]         hmem [rsfa_pkg::HIST_DEPTH];

  rsfa_pkg::bstate_t                  state_r;
  rsfa_pkg::bstate_t                  state_nxt;
  logic [rsfa_pkg::HADDR_W-1:0]       init_r;
  logic [rsfa_pkg::HADDR_W-1:0]       init_nxt;
  rsfa_pkg::rstate_t                  rm_rdata_r;
  logic [rsfa_pkg::CNT_W-1:0]         hm_rdata_r;
  rsfa_pkg::rstate_t                  rw_r;
  rsfa_pkg::rstate_t                  rw_nxt;
  logic [rsfa_pkg::BIN_W-1:0]         b_r;
  logic [rsfa_pkg::BIN_W-1:0]         b_nxt;
  logic                               pv_r;
  logic                               pv_nxt;
  logic [rsfa_pkg::BIG_W-1:0]         big_r;
  logic [rsfa_pkg::BIG_W-1:0]         big_nxt;
  logic [rsfa_pkg::WIDX_W-1:0]        widx_r;
  logic [rsfa_pkg::WIDX_W-1:0]        widx_nxt;
  logic signed [rsfa_pkg::WORD_W-1:0] val_r;
  logic signed [rsfa_pkg::WORD_W-1:0] val_nxt;
  logic [31:0]                        p1_r;
  logic [31:0]                        p1_nxt;
  logic                               vok_r;
  logic                               vok_nxt;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [rsfa_pkg::LABEL_W-1:0]       out_region_r;
  logic [rsfa_pkg::LABEL_W-1:0]       out_region_nxt;
  logic [rsfa_pkg::WIDX_W-1:0]        out_widx_r;
  logic [rsfa_pkg::WIDX_W-1:0]        out_widx_nxt;
  logic signed [rsfa_pkg::WORD_W-1:0] out_val_r;
  logic signed [rsfa_pkg::WORD_W-1:0] out_val_nxt;
  logic                               out_last_r;
  logic                               out_last_nxt;

  logic [rsfa_pkg::REGION_W-1:0]      rm_raddr;
  logic                               rm_we;
  logic [rsfa_pkg::REGION_W-1:0]      rm_waddr;
  rsfa_pkg::rstate_t                  rm_wdata;
  logic [rsfa_pkg::HADDR_W-1:0]       hm_raddr;
  logic                               hm_we;
  logic [rsfa_pkg::HADDR_W-1:0]       hm_waddr;
  logic [rsfa_pkg::CNT_W-1:0]         hm_wdata;

  logic [rsfa_pkg::HADDR_W-1:0]       hbase;
  rsfa_pkg::rstate_t                  acc_new;
  logic                               hit;
  logic [1:0]                         cls;
  logic [1:0]                         ax;
  logic signed [rsfa_pkg::SUM_W-1:0]  div_a;
  logic                               div_start;
  logic                               div_done;
  logic signed [rsfa_pkg::QUO_W-1:0]  div_q;
  logic signed [16:0]                 dx;
  logic signed [16:0]                 dy;
  logic signed [16:0]                 dz;
  logic [47:0]                        vol;
  logic signed [rsfa_pkg::WORD_W-1:0] wsel;

  rsfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (rw_r.count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    hbase = rsfa_pkg::HADDR_W'(q_head.region * rsfa_pkg::NBINS);

    acc_new = rm_rdata_r;
    acc_new.count = rm_rdata_r.count + rsfa_pkg::CNT_W'(1);
    for (int i = 0; i < 3; i++) begin
      if (mode[rsfa_pkg::MODE_MNRM]) begin
        acc_new.nsum[i] = rm_rdata_r.nsum[i]
                        + rsfa_pkg::SUM_W'($signed(q_head.nrm[i]));
      end
      if (mode[rsfa_pkg::MODE_MPOS]) begin
        acc_new.psum[i] = rm_rdata_r.psum[i]
                        + rsfa_pkg::SUM_W'($signed(q_head.pos[i]));
      end
      if (mode[rsfa_pkg::MODE_BOX3]) begin
        if ($signed(q_head.pos[i]) < $signed(rm_rdata_r.b3min[i])) begin
          acc_new.b3min[i] = q_head.pos[i];
        end
        if ($signed(q_head.pos[i]) > $signed(rm_rdata_r.b3max[i])) begin
          acc_new.b3max[i] = q_head.pos[i];
        end
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (mode[rsfa_pkg::MODE_BOX2]) begin
        if ($signed({1'b0, q_head.pix[i]}) < $signed(rm_rdata_r.b2min[i])) begin
          acc_new.b2min[i] = {1'b0, q_head.pix[i]};
        end
        if ($signed({1'b0, q_head.pix[i]}) > $signed(rm_rdata_r.b2max[i])) begin
          acc_new.b2max[i] = {1'b0, q_head.pix[i]};
        end
      end
    end

    hit = ({8'b0, hm_rdata_r} * rsfa_pkg::RATIO_W'(rsfa_pkg::BIN_RATIO))
          >= rsfa_pkg::RATIO_W'(rw_r.count);

    cls = rsfa_pkg::CLS_UNDEF;
    if ((mode[rsfa_pkg::MODE_HIST] || mode[rsfa_pkg::MODE_CURV]) && rw_r.count != '0) begin
      if (big_r == '0) begin
        cls = rsfa_pkg::CLS_UNDEF;
      end else if (big_r < rsfa_pkg::BIG_W'(rsfa_pkg::PLANAR_LIMIT)) begin
        cls = rsfa_pkg::CLS_PLANAR;
      end else if (big_r < rsfa_pkg::BIG_W'(rsfa_pkg::CURVED1D_LIMIT)) begin
        cls = rsfa_pkg::CLS_CURVED1D;
      end else begin
        cls = rsfa_pkg::CLS_CURVED2D;
      end
    end

    if (widx_r < rsfa_pkg::W_MEAN_P0) begin
      ax = 2'(widx_r - rsfa_pkg::W_MEAN_N0);
      div_a = $signed(rw_r.nsum[ax]);
    end else begin
      ax = 2'(widx_r - rsfa_pkg::W_MEAN_P0);
      div_a = $signed(rw_r.psum[ax]);
    end

    dx = 17'($signed(rw_r.b3max[0])) - 17'($signed(rw_r.b3min[0]));
    dy = 17'($signed(rw_r.b3max[1])) - 17'($signed(rw_r.b3min[1]));
    dz = 17'($signed(rw_r.b3max[2])) - 17'($signed(rw_r.b3min[2]));
    vol = 48'(p1_r) * 48'(dz[15:0]);

    case (widx_r) inside
      [rsfa_pkg::W_B3MIN0:rsfa_pkg::W_B3MAX0 - 5'd1]:
        wsel = rsfa_pkg::WORD_W'($signed(rw_r.b3min[2'(widx_r - rsfa_pkg::W_B3MIN0)]));
      [rsfa_pkg::W_B3MAX0:rsfa_pkg::W_B2MIN_X - 5'd1]:
        wsel = rsfa_pkg::WORD_W'($signed(rw_r.b3max[2'(widx_r - rsfa_pkg::W_B3MAX0)]));
      rsfa_pkg::W_B2MIN_X: wsel = rsfa_pkg::WORD_W'($signed(rw_r.b2min[0]));
      rsfa_pkg::W_B2MIN_Y: wsel = rsfa_pkg::WORD_W'($signed(rw_r.b2min[1]));
      rsfa_pkg::W_B2MAX_X: wsel = rsfa_pkg::WORD_W'($signed(rw_r.b2max[0]));
      rsfa_pkg::W_B2MAX_Y: wsel = rsfa_pkg::WORD_W'($signed(rw_r.b2max[1]));
      rsfa_pkg::W_CLASS:   wsel = rsfa_pkg::WORD_W'(cls);
      default:             wsel = rsfa_pkg::WORD_W'(rw_r.count);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    init_nxt = init_r;
    rw_nxt = rw_r;
    b_nxt = b_r;
    pv_nxt = pv_r;
    big_nxt = big_r;
    widx_nxt = widx_r;
    val_nxt = val_r;
    p1_nxt = p1_r;
    vok_nxt = vok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_region_nxt = out_region_r;
    out_widx_nxt = out_widx_r;
    out_val_nxt = out_val_r;
    out_last_nxt = out_last_r;
    rm_raddr = q_head.region;
    rm_we = 1'b0;
    rm_waddr = q_head.region;
    rm_wdata = rsfa_pkg::rstate_reset();
    hm_raddr = hbase + rsfa_pkg::HADDR_W'(q_head.bin);
    hm_we = 1'b0;
    hm_waddr = hbase + rsfa_pkg::HADDR_W'(q_head.bin);
    hm_wdata = '0;
    pop = 1'b0;
    div_start = 1'b0;
    init_busy = (state_r == rsfa_pkg::BS_INIT);

    unique case (state_r)
      rsfa_pkg::BS_INIT: begin
        hm_we = 1'b1;
        hm_waddr = init_r;
        rm_we = (init_r < rsfa_pkg::HADDR_W'(rsfa_pkg::MAX_REGIONS));
        rm_waddr = rsfa_pkg::REGION_W'(init_r);
        init_nxt = init_r + rsfa_pkg::HADDR_W'(1);
        if (init_r == rsfa_pkg::HADDR_W'(rsfa_pkg::HIST_DEPTH - 1)) begin
          state_nxt = rsfa_pkg::BS_IDLE;
        end
      end
      rsfa_pkg::BS_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_head.action == rsfa_pkg::ACT_READ) ? rsfa_pkg::BS_RO_LAT
                                                           : rsfa_pkg::BS_ACC;
        end
      end
      rsfa_pkg::BS_ACC: begin
        pop = 1'b1;
        state_nxt = rsfa_pkg::BS_IDLE;
        if (rm_rdata_r.count != rsfa_pkg::COUNT_MAX) begin
          rm_we = 1'b1;
          rm_wdata = acc_new;
          hm_we = mode[rsfa_pkg::MODE_HIST];
          hm_wdata = hm_rdata_r + rsfa_pkg::CNT_W'(1);
        end
      end
      rsfa_pkg::BS_RO_LAT: begin
        rw_nxt = rm_rdata_r;
        b_nxt = '0;
        pv_nxt = 1'b0;
        big_nxt = '0;
        state_nxt = rsfa_pkg::BS_WALK;
      end
      rsfa_pkg::BS_WALK: begin
        hm_raddr = hbase + rsfa_pkg::HADDR_W'(b_r);
        hm_waddr = hbase + rsfa_pkg::HADDR_W'(b_r);
        hm_we = 1'b1;
        pv_nxt = 1'b1;
        if (pv_r && hit) begin
          big_nxt = big_r + rsfa_pkg::BIG_W'(1);
        end
        if (b_r == rsfa_pkg::BIN_W'(rsfa_pkg::NBINS - 1)) begin
          state_nxt = rsfa_pkg::BS_WALK_END;
        end else begin
          b_nxt = b_r + rsfa_pkg::BIN_W'(1);
        end
      end
      rsfa_pkg::BS_WALK_END: begin
        if (hit) begin
          big_nxt = big_r + rsfa_pkg::BIG_W'(1);
        end
        widx_nxt = rsfa_pkg::W_COUNT;
        state_nxt = rsfa_pkg::BS_WORD;
      end
      rsfa_pkg::BS_WORD: begin
        if (widx_r >= rsfa_pkg::W_MEAN_N0 && widx_r <= rsfa_pkg::W_MEAN_P2) begin
          div_start = 1'b1;
          state_nxt = rsfa_pkg::BS_DIV;
        end else if (widx_r == rsfa_pkg::W_VOLUME) begin
          p1_nxt = 32'(dx[15:0]) * 32'(dy[15:0]);
          vok_nxt = mode[rsfa_pkg::MODE_BOX3] && (rw_r.count != '0)
                    && !dx[16] && !dy[16] && !dz[16];
          state_nxt = rsfa_pkg::BS_MUL;
        end else begin
          val_nxt = wsel;
          state_nxt = rsfa_pkg::BS_EMIT;
        end
      end
      rsfa_pkg::BS_DIV: begin
        if (div_done) begin
          val_nxt = rsfa_pkg::WORD_W'(div_q);
          state_nxt = rsfa_pkg::BS_EMIT;
        end
      end
      rsfa_pkg::BS_MUL: begin
        val_nxt = vok_r ? rsfa_pkg::WORD_W'(vol) : '0;
        state_nxt = rsfa_pkg::BS_EMIT;
      end
      rsfa_pkg::BS_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_region_nxt = rsfa_pkg::LABEL_W'(q_head.region) + rsfa_pkg::LABEL_W'(1);
          out_widx_nxt = widx_r;
          out_val_nxt = val_r;
          out_last_nxt = (widx_r == rsfa_pkg::W_VOLUME);
          if (widx_r == rsfa_pkg::W_VOLUME) begin
            state_nxt = rsfa_pkg::BS_CLR;
          end else begin
            widx_nxt = widx_r + rsfa_pkg::WIDX_W'(1);
            state_nxt = rsfa_pkg::BS_WORD;
          end
        end
      end
      rsfa_pkg::BS_CLR: begin
        rm_we = 1'b1;
        pop = 1'b1;
        state_nxt = rsfa_pkg::BS_IDLE;
      end
      default: begin
        state_nxt = rsfa_pkg::BS_IDLE;
      end
    endcase

    out_valid = out_valid_r;
    out_region = out_region_r;
    out_word_index = out_widx_r;
    out_word_value = out_val_r;
    out_last_word = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsfa_pkg::BS_INIT;
      init_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rw_r <= rw_nxt;
    b_r <= b_nxt;
    pv_r <= pv_nxt;
    big_r <= big_nxt;
    widx_r <= widx_nxt;
    val_r <= val_nxt;
    p1_r <= p1_nxt;
    vok_r <= vok_nxt;
    out_region_r <= out_region_nxt;
    out_widx_r <= out_widx_nxt;
    out_val_r <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (rm_we) begin
      rmem[rm_waddr] <= rm_wdata;
    end
    rm_rdata_r <= rmem[rm_raddr];
  end

  always_ff @(posedge clk) begin
    if (hm_we) begin
      hmem[hm_waddr] <= hm_wdata;
    end
    hm_rdata_r <= hmem[hm_raddr];
  end

endmodule
`default_nettype wire

[design/region_surface_feature_accumulator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Region surface feature accumulator
// Accumulates per-region normal and position statistics, boxes and a
// normal histogram, and reads out 19 feature words per region.
// ----------------------------------------------------------------------------
// After reset the block spends its first cycles clearing the histogram memory,
// one bin per cycle, and holds in_ready low meanwhile. A pixel then takes
// a read step and a write step of the region state and histogram bin
// through their single ports. A readout walks over the region's histogram
// bins, which also clears them, runs a division for each of the six means
// and a multiply for the volume, selects each of the twelve other words,
// emits each of the 19 words as the output accepts it, and fetches and
// clears the region state. A two-entry queue lets new requests be accepted
// while the back end is busy.
module region_surface_feature_accumulator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rsfa_pkg::MODE_W-1:0]       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_action,
  input  wire logic [rsfa_pkg::LABEL_W-1:0]      in_label,
  input  wire logic [rsfa_pkg::PIX_W-1:0]        in_pix_x,
  input  wire logic [rsfa_pkg::PIX_W-1:0]        in_pix_y,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_normal_x,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_normal_y,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_normal_z,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_pos_x,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_pos_y,
  input  wire logic signed [rsfa_pkg::VEC_W-1:0] in_pos_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rsfa_pkg::LABEL_W-1:0]           out_region,
  output logic [rsfa_pkg::WIDX_W-1:0]            out_word_index,
  output logic signed [rsfa_pkg::WORD_W-1:0]     out_word_value,
  output logic                                   out_last_word
);

  logic [rsfa_pkg::MODE_W-1:0] mode_r;
  logic [rsfa_pkg::MODE_W-1:0] mode_nxt;
  logic                        push;
  rsfa_pkg::qent_t             push_data;
  logic                        pop;
  logic                        q_full;
  logic                        q_valid;
  rsfa_pkg::qent_t             q_head;
  logic                        init_busy;

  always_comb begin
    mode_nxt = cfg_we ? cfg_wdata : mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rsfa_pkg::MODE_RESET;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  rsfa_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_label    (in_label),
    .in_pix_x    (in_pix_x),
    .in_pix_y    (in_pix_y),
    .in_normal_x (in_normal_x),
    .in_normal_y (in_normal_y),
    .in_normal_z (in_normal_z),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .q_full      (q_full),
    .init_busy   (init_busy),
    .push        (push),
    .push_data   (push_data)
  );

  rsfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  rsfa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mode           (mode_r),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .pop            (pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_region     (out_region),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_last_word  (out_last_word)
  );

endmodule
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Region surface feature accumulator testbench
// Sends labeled pixel and readout requests over a valid/ready channel.
// Every accepted request runs through a behavioral model of the region
// statistics, and each readout word is checked in order. The stimulus starts
// from a directed table and continues with random pixel runs ended by readouts
// and single requests that may carry bad labels. It covers several feature
// modes, random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic                    act;
    logic [LABEL_W-1:0]      label;
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic signed [VEC_W-1:0] nx;
    logic signed [VEC_W-1:0] ny;
    logic signed [VEC_W-1:0] nz;
    logic signed [VEC_W-1:0] qx;
    logic signed [VEC_W-1:0] qy;
    logic signed [VEC_W-1:0] qz;
  } request_t;

  typedef struct packed {
    logic [LABEL_W-1:0]       region;
    logic [WIDX_W-1:0]        widx;
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } feature_word_t;

  typedef struct {
    request_t req;
    bit       typed;
    int       typed_count;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [MODE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [LABEL_W-1:0] in_label = '0;
  logic [PIX_W-1:0] in_pix_x = '0;
  logic [PIX_W-1:0] in_pix_y = '0;
  logic signed [VEC_W-1:0] in_normal_x = '0;
  logic signed [VEC_W-1:0] in_normal_y = '0;
  logic signed [VEC_W-1:0] in_normal_z = '0;
  logic signed [VEC_W-1:0] in_pos_x = '0;
  logic signed [VEC_W-1:0] in_pos_y = '0;
  logic signed [VEC_W-1:0] in_pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LABEL_W-1:0] out_region;
  logic [WIDX_W-1:0] out_word_index;
  logic signed [WORD_W-1:0] out_word_value;
  logic out_last_word;

  region_surface_feature_accumulator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_label(in_label),
    .in_pix_x(in_pix_x), .in_pix_y(in_pix_y),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_region(out_region), .out_word_index(out_word_index),
    .out_word_value(out_word_value), .out_last_word(out_last_word)
  );

  always #5 clk = ~clk;

  // Model of the per-region statistics.
  logic [MODE_W-1:0] mode_shadow = MODE_RESET;
  int unsigned region_count [MAX_REGIONS];
  longint normal_total [MAX_REGIONS][3];
  longint position_total [MAX_REGIONS][3];
  int box3_lo [MAX_REGIONS][3];
  int box3_hi [MAX_REGIONS][3];
  int box2_lo [MAX_REGIONS][2];
  int box2_hi [MAX_REGIONS][2];
  int unsigned bin_count [MAX_REGIONS][NBINS];

  feature_word_t pending_words[$];
  int errors = 0;
  int words_checked = 0;
  int pixels_sent = 0;
  int readouts_sent = 0;
  bit idle_en = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d (word %0d)", what, got, want, words_checked);
  endtask

  function automatic void clear_region_model(input int r);
    region_count[r] = 0;
    for (int i = 0; i < 3; i++) begin
      normal_total[r][i] = 0;
      position_total[r][i] = 0;
      box3_lo[r][i] = 32767;
      box3_hi[r][i] = -32768;
    end
    for (int i = 0; i < 2; i++) begin
      box2_lo[r][i] = BOX2_HI;
      box2_hi[r][i] = BOX2_LO;
    end
    for (int i = 0; i < NBINS; i++) bin_count[r][i] = 0;
  endfunction

  function automatic int axis_bin(input logic signed [VEC_W-1:0] v);
    longint t;
    longint b;
    t = longint'(v) * HALF_SIDE + longint'(HALF_SIDE) * 16384;
    if (t < 0) return 0;
    b = (t + 8192) >>> 14;
    return (b > HIST_SIDE - 1) ? HIST_SIDE - 1 : int'(b);
  endfunction

  function automatic longint rounded_mean(input longint s, input int unsigned n);
    longint a;
    longint q;
    if (n == 0) return 0;
    a = (s < 0) ? -s : s;
    q = (a + n / 2) / n;
    return (s < 0) ? -q : q;
  endfunction

  function automatic void predict_request(input request_t q, input bit typed, input int tcount);
    int r;
    longint nv [3];
    longint pv [3];
    int pix [2];
    longint w [19];
    int unsigned n;
    int big;
    feature_word_t fw;
    if (q.label == 0 || q.label > MAX_REGIONS) return;
    r = q.label - 1;
    nv = '{q.nx, q.ny, q.nz};
    pv = '{q.qx, q.qy, q.qz};
    if (q.act == ACT_ACCUM) begin
      if (region_count[r] >= COUNT_MAX) return;
      region_count[r]++;
      pix = '{int'(q.px), int'(q.py)};
      if (mode_shadow[MODE_HIST])
        bin_count[r][axis_bin(q.nx) * HIST_SIDE + axis_bin(q.ny)]++;
      for (int i = 0; i < 3; i++) begin
        if (mode_shadow[MODE_MNRM]) normal_total[r][i] += nv[i];
        if (mode_shadow[MODE_MPOS]) position_total[r][i] += pv[i];
        if (mode_shadow[MODE_BOX3]) begin
          if (pv[i] < box3_lo[r][i]) box3_lo[r][i] = int'(pv[i]);
          if (pv[i] > box3_hi[r][i]) box3_hi[r][i] = int'(pv[i]);
        end
      end
      if (mode_shadow[MODE_BOX2]) begin
        for (int i = 0; i < 2; i++) begin
          if (pix[i] < box2_lo[r][i]) box2_lo[r][i] = pix[i];
          if (pix[i] > box2_hi[r][i]) box2_hi[r][i] = pix[i];
        end
      end
      return;
    end
    n = region_count[r];
    w[0] = n;
    for (int i = 0; i < 3; i++) begin
      w[1 + i] = rounded_mean(normal_total[r][i], n);
      w[4 + i] = rounded_mean(position_total[r][i], n);
      w[7 + i] = box3_lo[r][i];
      w[10 + i] = box3_hi[r][i];
    end
    w[13] = box2_lo[r][0];
    w[14] = box2_lo[r][1];
    w[15] = box2_hi[r][0];
    w[16] = box2_hi[r][1];
    w[17] = CLS_UNDEF;
    if ((mode_shadow[MODE_HIST] || mode_shadow[MODE_CURV]) && n > 0) begin
      big = 0;
      for (int i = 0; i < NBINS; i++)
        if (longint'(bin_count[r][i]) * BIN_RATIO >= n) big++;
      if (big == 0) w[17] = CLS_UNDEF;
      else if (big < PLANAR_LIMIT) w[17] = CLS_PLANAR;
      else if (big < CURVED1D_LIMIT) w[17] = CLS_CURVED1D;
      else w[17] = CLS_CURVED2D;
    end
    w[18] = 0;
    if (mode_shadow[MODE_BOX3] && n > 0) begin
      if (box3_hi[r][0] >= box3_lo[r][0] && box3_hi[r][1] >= box3_lo[r][1]
          && box3_hi[r][2] >= box3_lo[r][2])
        w[18] = longint'(box3_hi[r][0] - box3_lo[r][0]) * (box3_hi[r][1] - box3_lo[r][1])
                * (box3_hi[r][2] - box3_lo[r][2]);
    end
    if (typed) w[0] = tcount;
    for (int k = 0; k < 19; k++) begin
      fw.region = q.label;
      fw.widx = WIDX_W'(k);
      fw.value = WORD_W'(w[k]);
      fw.last = (WIDX_W'(k) == W_VOLUME);
      pending_words.insert(pending_words.size(), fw);
    end
    clear_region_model(r);
  endfunction

  // Output checker.
  always @(posedge clk) begin
    feature_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word index", out_word_index, -1);
      end else begin
        want = pending_words.pop_front();
        if (out_region !== want.region) report_mismatch("region", out_region, want.region);
        if (out_word_index !== want.widx) report_mismatch("word_index", out_word_index, want.widx);
        if (out_word_value !== want.value)
          report_mismatch("word_value", out_word_value, want.value);
        if (out_last_word !== want.last) report_mismatch("last_word", out_last_word, want.last);
      end
      words_checked++;
    end
  end

  // Receiver stalls.
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d words outstanding.", pending_words.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Called just after a rising edge; returns after acceptance and any pause.
  task automatic offer_request(input request_t q, input bit typed = 0, input int tcount = 0);
    in_valid <= 1'b1;
    in_action <= q.act;
    in_label <= q.label;
    in_pix_x <= q.px;
    in_pix_y <= q.py;
    in_normal_x <= q.nx;
    in_normal_y <= q.ny;
    in_normal_z <= q.nz;
    in_pos_x <= q.qx;
    in_pos_y <= q.qy;
    in_pos_z <= q.qz;
    do @(posedge clk); while (!in_ready);
    predict_request(q, typed, tcount);
    if (q.label != 0 && q.label <= MAX_REGIONS) begin
      if (q.act == ACT_READ) readouts_sent++;
      else pixels_sent++;
    end
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic request_t mk(input logic a, input int lbl, input int px, input int py,
                                  input int n0, input int n1, input int n2,
                                  input int p0, input int p1, input int p2);
    request_t q;
    q = '{a, LABEL_W'(lbl), PIX_W'(px), PIX_W'(py), VEC_W'(n0), VEC_W'(n1), VEC_W'(n2),
          VEC_W'(p0), VEC_W'(p1), VEC_W'(p2)};
    return q;
  endfunction

  function automatic request_t random_pixel(input int lbl, input bit narrow,
                                            input int cx, input int cy);
    request_t q;
    q = mk(ACT_ACCUM, lbl, $urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0, 0,
           $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
    if (narrow) begin
      q.nx = VEC_W'(cx + $urandom_range(0, 1000) - 500);
      q.ny = VEC_W'(cy + $urandom_range(0, 1000) - 500);
    end else if ($urandom_range(0, 9) == 0) begin
      q.nx = VEC_W'($urandom_range(0, 65535));
      q.ny = VEC_W'($urandom_range(0, 65535));
    end else begin
      q.nx = VEC_W'($urandom_range(0, 32768) - 16384);
      q.ny = VEC_W'($urandom_range(0, 32768) - 16384);
    end
    q.nz = VEC_W'($urandom_range(0, 32768) - 16384);
    return q;
  endfunction

  task automatic write_mode(input logic [MODE_W-1:0] m);
    in_valid <= 1'b0;
    wait (pending_words.size() == 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_shadow = m;
  endtask

  task automatic random_phase(input int budget);
    int sent;
    int lbl;
    int run;
    bit narrow;
    int cx;
    int cy;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: lbl = 0;
          1: lbl = $urandom_range(MAX_REGIONS + 1, 127);
          default: lbl = $urandom_range(1, MAX_REGIONS);
        endcase
        offer_request(mk(1'($urandom_range(0, 1)), lbl, 0, 0, 0, 0, 0, 0, 0, 0));
        sent++;
      end else begin
        lbl = $urandom_range(1, MAX_REGIONS);
        run = $urandom_range(1, 12);
        narrow = $urandom_range(0, 1);
        cx = $urandom_range(0, 32768) - 16384;
        cy = $urandom_range(0, 32768) - 16384;
        repeat (run) offer_request(random_pixel(lbl, narrow, cx, cy));
        offer_request(mk(ACT_READ, lbl, 0, 0, 0, 0, 0, 0, 0, 0));
        sent += run;
      end
    end
  endtask

  table_row_t directed [] = '{
    '{mk(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0},
    '{mk(ACT_ACCUM, 0, 5, 5, 100, 100, 100, 7, 7, 7), 0, 0},
    '{mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0},
    '{mk(ACT_READ, 127, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0},
    '{mk(ACT_ACCUM, 65, 1, 1, 0, 0, 0, 1, 1, 1), 0, 0},
    '{mk(ACT_ACCUM, 64, 4095, 4095, 16384, 16384, 16384, 32767, 32767, 32767), 0, 0},
    '{mk(ACT_ACCUM, 64, 0, 0, -16384, -16384, -16384, -32768, -32768, -32768), 0, 0},
    '{mk(ACT_ACCUM, 64, 2048, 17, -32768, 32767, 0, 0, -1, 1), 0, 0},
    '{mk(ACT_READ, 64, 0, 0, 0, 0, 0, 0, 0, 0), 1, 3},
    '{mk(ACT_ACCUM, 2, 100, 200, 0, 0, 16384, 10, -10, 3), 0, 0},
    '{mk(ACT_ACCUM, 2, 101, 199, 1, -1, 16383, 11, -11, 4), 0, 0},
    '{mk(ACT_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0), 1, 2},
    '{mk(ACT_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0},
    '{mk(ACT_ACCUM, 3, 7, 7, 8192, -8192, 0, -5, -5, -5), 0, 0},
    '{mk(ACT_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1}
  };

  logic [MODE_W-1:0] phase_modes [] = '{6'd63, 6'd0, 6'd1, 6'd2, 6'd21, 6'd42};

  initial begin
    for (int r = 0; r < MAX_REGIONS; r++) clear_region_model(r);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) offer_request(directed[i].req, directed[i].typed,
                                        directed[i].typed_count);
    idle_en = 1'b1;
    foreach (phase_modes[i]) begin
      write_mode(phase_modes[i]);
      if (i == 0) hold_req = 1'b1;
      random_phase((i == 0) ? 16 : 8);
    end
    write_mode(6'($urandom_range(0, 63)));
    random_phase(8);
    idle_en = 1'b0;
    write_mode(MODE_RESET);
    random_phase(8);
    in_valid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixels and %0d readouts over %0d feature modes; checked %0d words.",
             pixels_sent, readouts_sent, phase_modes.size() + 2, words_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rsfa_pkg.sv
design/rsfa_front.sv
design/rsfa_queue.sv
design/rsfa_div.sv
design/rsfa_back.sv
design/region_surface_feature_accumulator.sv
verif/tb.sv
